// ===== design/epwm_pkg.sv =====
package epwm_pkg;

  // Field widths
  localparam int unsigned LimitWidth  = 16;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned PhaseWidth  = 2;

  // Limit after reset
  localparam logic [LimitWidth-1:0] DEFAULT_TIMEOUT = 16'd6000;

  // Input item kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Measurement phases
  localparam logic [PhaseWidth-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseWidth-1:0] PH_WAIT = 2'd1;
  localparam logic [PhaseWidth-1:0] PH_HIGH = 2'd2;

  // Result status codes
  localparam logic [StatusWidth-1:0] ST_OK         = 2'd0;
  localparam logic [StatusWidth-1:0] ST_NO_RISE    = 2'd1;
  localparam logic [StatusWidth-1:0] ST_STUCK_HIGH = 2'd2;

  // One measurement result
  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  width;
  } result_t;

endpackage

// ===== design/epwm_step.sv =====
// Phase and tick counter of the meter; works out one item per cycle while fire is high.
module epwm_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic                                 kind,
  input  logic                                 echo_level,
  input  logic [epwm_pkg::LimitWidth-1:0]      timeout_limit,
  output logic                                 res_valid,
  output epwm_pkg::result_t                    res
);

  logic [epwm_pkg::PhaseWidth-1:0] phase_r;
  logic [epwm_pkg::PhaseWidth-1:0] phase_nxt;
  logic [epwm_pkg::CountWidth-1:0] tick_count_r;
  logic [epwm_pkg::CountWidth-1:0] tick_count_nxt;
  logic [epwm_pkg::CountWidth:0]   count_inc;
  logic                            over_limit;

  // Compare one bit wider so the count never wraps
  assign count_inc  = {1'b0, tick_count_r} + {{epwm_pkg::CountWidth{1'b0}}, 1'b1};
  assign over_limit = count_inc > {1'b0, timeout_limit};

  // Decide next phase, count and any result
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    res_valid      = 1'b0;
    res.status     = epwm_pkg::ST_OK;
    res.width      = '0;
    if (kind == epwm_pkg::KIND_START) begin
      phase_nxt      = epwm_pkg::PH_WAIT;
      tick_count_nxt = '0;
    end else begin
      case (phase_r)
        epwm_pkg::PH_WAIT: begin
          if (!echo_level) begin
            if (over_limit) begin
              res_valid      = 1'b1;
              res.status     = epwm_pkg::ST_NO_RISE;
              phase_nxt      = epwm_pkg::PH_IDLE;
              tick_count_nxt = '0;
            end else begin
              tick_count_nxt = count_inc[epwm_pkg::CountWidth-1:0];
            end
          end else if (timeout_limit == '0) begin
            res_valid      = 1'b1;
            res.status     = epwm_pkg::ST_STUCK_HIGH;
            phase_nxt      = epwm_pkg::PH_IDLE;
            tick_count_nxt = '0;
          end else begin
            phase_nxt      = epwm_pkg::PH_HIGH;
            tick_count_nxt = {{(epwm_pkg::CountWidth-1){1'b0}}, 1'b1};
          end
        end
        epwm_pkg::PH_HIGH: begin
          if (!echo_level) begin
            res_valid      = 1'b1;
            res.status     = epwm_pkg::ST_OK;
            res.width      = tick_count_r;
            phase_nxt      = epwm_pkg::PH_IDLE;
            tick_count_nxt = '0;
          end else if (over_limit) begin
            res_valid      = 1'b1;
            res.status     = epwm_pkg::ST_STUCK_HIGH;
            phase_nxt      = epwm_pkg::PH_IDLE;
            tick_count_nxt = '0;
          end else begin
            tick_count_nxt = count_inc[epwm_pkg::CountWidth-1:0];
          end
        end
        default: begin
          phase_nxt = epwm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Advance state on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= epwm_pkg::PH_IDLE;
      tick_count_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == epwm_pkg::PH_IDLE |-> tick_count_r == '0)
    else $error("tick count not clear while idle");

  a_high_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == epwm_pkg::PH_HIGH |-> tick_count_r != '0)
    else $error("zero width count while echo high");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind == epwm_pkg::KIND_START |=>
      phase_r == epwm_pkg::PH_WAIT && tick_count_r == '0)
    else $error("start did not arm the meter");

endmodule

// ===== design/echo_pulse_width_meter.sv =====
// Channel | Dir | Handshake           | Payload (lowest bit first)
// in_     | in  | in_tvalid/in_tready | tuser: kind; tdata: echo_level, zero pad
// out_    | out | out_tvalid/out_tready | tdata: status[1:0], width[17:2], zero pad
// cfg_    | in  | cfg_we              | cfg_wdata: timeout_limit
//
// One item per clock, except while a result stalls: an item is registered on
// transfer, evaluated by the phase/count logic, and when it advances its result
// lands in the output register and raises out_tvalid.
// Synchronous active-low reset clears the phase, counter and valid flags and
// loads the default limit. A full output register that is not being read stalls
// only items that would produce a result; items without a result keep flowing.
module echo_pulse_width_meter #(
  parameter logic [epwm_pkg::LimitWidth-1:0] TimeoutReset = epwm_pkg::DEFAULT_TIMEOUT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] echo_level, [7:1] zero
  input  logic                              in_tuser,   // [0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // [1:0] status, [17:2] width
  input  logic                              cfg_we,
  input  logic [epwm_pkg::LimitWidth-1:0]   cfg_wdata   // timeout_limit
);

  logic                              in_valid_r;
  logic                              kind_r;
  logic                              level_r;
  logic [epwm_pkg::LimitWidth-1:0]   limit_r;
  logic                              out_valid_r;
  epwm_pkg::result_t                 out_res_r;
  logic                              res_valid;
  epwm_pkg::result_t                 res;
  logic                              advance;
  logic                              in_xfer;

  // Process the held item unless its result has nowhere to go
  assign advance   = in_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // Hold the timeout limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TimeoutReset;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_tuser;
      level_r <= in_tdata[0];
    end
  end

  epwm_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .kind          (kind_r),
    .echo_level    (level_r),
    .timeout_limit (limit_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.width, out_res_r.status};

  a_error_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != epwm_pkg::ST_OK |-> out_res_r.width == '0)
    else $error("error result with nonzero width");

  a_ok_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == epwm_pkg::ST_OK |-> out_res_r.width != '0)
    else $error("ok result with zero width");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.status <= epwm_pkg::ST_STUCK_HIGH)
    else $error("unused status code on output");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(kind_r) && $stable(level_r))
    else $error("stalled item lost from input register");

endmodule

// ===== bench/echo_width_checker.sv =====
module echo_width_checker
  import epwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] echo_level, [7:1] zero
  input  logic                  in_tuser,   // [0] kind
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [23:0]           out_tdata,  // [1:0] status, [17:2] width, [23:18] zero
  input  logic                  cfg_we,
  input  logic [LimitWidth-1:0] cfg_wdata,  // timeout_limit
  output int                    fail_count,
  output int                    pending
);

  // Shadow copy of the register and the measurement state
  logic [LimitWidth-1:0] limit_q;
  logic [PhaseWidth-1:0] phase_q;
  logic [CountWidth-1:0] ticks_q;
  result_t               expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Advance the measurement by one item; return 1 when it ends with a result
  function automatic bit measure_echo(input logic kind, input logic level,
                                      output result_t res);
    int unsigned next_count;
    bit          done;
    done       = 1'b0;
    res        = '0;
    next_count = 0;
    if (kind == KIND_START) begin
      phase_q = PH_WAIT;
      ticks_q = '0;
    end else if (phase_q == PH_WAIT) begin
      if (level == 1'b0) begin
        next_count = int'(ticks_q) + 1;
        if (next_count > int'(limit_q)) begin
          res.status = ST_NO_RISE;
          done       = 1'b1;
        end else begin
          ticks_q = CountWidth'(next_count);
        end
      end else begin
        // the rising sample already counts towards the width
        phase_q = PH_HIGH;
        if (limit_q < 1) begin
          res.status = ST_STUCK_HIGH;
          done       = 1'b1;
        end else begin
          ticks_q = CountWidth'(1);
        end
      end
    end else if (phase_q == PH_HIGH) begin
      if (level == 1'b0) begin
        res.status = ST_OK;
        res.width  = ticks_q;
        done       = 1'b1;
      end else begin
        next_count = int'(ticks_q) + 1;
        if (next_count > int'(limit_q)) begin
          res.status = ST_STUCK_HIGH;
          done       = 1'b1;
        end else begin
          ticks_q = CountWidth'(next_count);
        end
      end
    end else begin
      phase_q = PH_IDLE;
    end
    if (done) begin
      phase_q = PH_IDLE;
      ticks_q = '0;
    end
    return done;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      limit_q = DEFAULT_TIMEOUT;
      phase_q = PH_IDLE;
      ticks_q = '0;
      expected_results.delete();
    end else begin
      // Compare each result transfer with the oldest expectation
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.width  = out_tdata[17:2];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got status %0d width %0d",
                   $time, got.status, got.width);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.width !== want.width) begin
            $display("%0t: width expected %0d, got %0d", $time, want.width, got.width);
            fail_count++;
          end
          if (out_tdata[23:18] !== 6'd0) begin
            $display("%0t: padding expected 0, got %0h", $time, out_tdata[23:18]);
            fail_count++;
          end
        end
      end
      // Take register writes, then predict from each input transfer
      if (cfg_we) begin
        limit_q = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (measure_echo(in_tuser, in_tdata[0], want)) begin
          expected_results.push_back(want);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/echo_pulse_width_meter_tb.sv =====
module echo_pulse_width_meter_tb;
  import epwm_pkg::*;

  localparam int unsigned ItemTarget   = 1350;
  localparam int unsigned DirectedLen  = 22;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned LongHold     = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [0] echo_level, [7:1] zero
  logic                  in_tuser;   // [0] kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;  // [1:0] status, [17:2] width, [23:18] zero
  logic                  cfg_we;
  logic [LimitWidth-1:0] cfg_wdata;  // timeout_limit

  int          fail_count;
  int          pending;
  int unsigned items_sent   = 0;
  int unsigned send_gap_max = 8;
  int unsigned recv_gap_max = 8;
  int unsigned idle_cycles  = 0;
  bit          hold_req     = 1'b0;

  echo_pulse_width_meter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  echo_width_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one item after a random gap and hold it until the transfer
  task automatic push_item(input logic kind, input logic level);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {7'd0, level};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Drain the block, let the pipeline settle, then write the limit
  task automatic set_limit(input logic [LimitWidth-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // One armed measurement with random wait and pulse lengths up to one past the limit, capped at 41
  task automatic measure_once(input logic [LimitWidth-1:0] lim);
    int unsigned span;
    int unsigned wait_len;
    int unsigned high_len;
    span         = (lim > 40) ? 40 : int'(lim);
    wait_len     = $urandom_range(0, span + 1);
    high_len     = $urandom_range(1, span + 1);
    send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    push_item(KIND_START, 1'($urandom_range(0, 1)));
    repeat (wait_len) push_item(KIND_SAMPLE, 1'b0);
    // occasionally re-arm part way through
    if ($urandom_range(0, 7) == 0) begin
      push_item(KIND_START, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) push_item(KIND_SAMPLE, 1'b0);
    end
    repeat (high_len) push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b0);
    // sprinkle unstructured items
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result receiver: random stalls, with one long hold on request
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end
      if (hold_req) begin
        stall    = LongHold;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      @(negedge clk);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [LimitWidth-1:0] lim;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_START;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Samples while idle are dropped
    push_item(KIND_SAMPLE, 1'b0);
    push_item(KIND_SAMPLE, 1'b1);
    // Plain pulse at the reset limit
    push_item(KIND_START, 1'b1);
    push_item(KIND_SAMPLE, 1'b0);
    push_item(KIND_SAMPLE, 1'b0);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b0);
    // Re-arm while high, then a single-sample pulse
    push_item(KIND_START, 1'b0);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_START, 1'b1);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b0);

    // Limit of one: both timeouts and a rise on the first sample
    set_limit(16'd1);
    push_item(KIND_START, 1'b0);
    push_item(KIND_SAMPLE, 1'b0);
    push_item(KIND_SAMPLE, 1'b0);
    push_item(KIND_START, 1'b0);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_START, 1'b1);
    push_item(KIND_SAMPLE, 1'b1);
    push_item(KIND_SAMPLE, 1'b0);

    // Random measurements over a range of limits
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       lim = 16'd65534;
        1:       lim = 16'd2;
        2:       lim = 16'd1;
        3:       lim = 16'd7;
        4:       lim = 16'd3;
        5:       lim = 16'd20;
        6:       lim = 16'd4;
        default: lim = LimitWidth'($urandom_range(1, 40));
      endcase
      set_limit(lim);
      // hold the receiver off while results pile up
      if (p == 2) begin
        hold_req = 1'b1;
      end
      while (items_sent < DirectedLen + (p + 1) * (ItemTarget - DirectedLen) / PhaseCount) begin
        measure_once(lim);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== echo_pulse_width_meter.f =====
design/epwm_pkg.sv
design/epwm_step.sv
design/echo_pulse_width_meter.sv
bench/echo_width_checker.sv
bench/echo_pulse_width_meter_tb.sv
